// File: hdl/sprite_entry_strip_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// Sprite entry strip decoder - assertion macros
// Concurrent check helpers shared by the queue and back-end RTL files.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ENTRY_STRIP_DECODER_CORE_MACROS_SVH
`define SPRITE_ENTRY_STRIP_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define SESD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SESD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/sesd_pkg.sv
// ----------------------------------------------------------------------------
// Sprite entry strip decoder - package
// Shared types and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sesd_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 40;

	localparam logic signed [9:0] FLIP_ORIGIN = 10'sd240;

	// decoded entry, front to back
	typedef struct packed {
		logic [8:0]        code;
		logic [3:0]        color;
		logic              flip;
		logic signed [9:0] pos_x;
		logic signed [9:0] pos_y;
		logic [1:0]        top;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} push_t;

endpackage

`default_nettype wire

// File: hdl/sesd_front.sv
// ----------------------------------------------------------------------------
// Sprite entry strip decoder - front end
// Accepts attribute entries and decodes code, colour, positions and height.
// ----------------------------------------------------------------------------
`default_nettype none

module sesd_front
	import sesd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic                 cfg_wr_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	input  wire logic                 q_full,
	output push_t                     push_o
);

	logic              flip_q;
	logic [7:0]        b0, b1, b2, b3;
	logic signed [9:0] sx, sy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q <= 1'b0;
		end else if (cfg_wr_en) begin
			flip_q <= cfg_wr_data;
		end
	end

	assign b0 = s_tdata[7:0];
	assign b1 = s_tdata[15:8];
	assign b2 = s_tdata[23:16];
	assign b3 = s_tdata[31:24];

	assign sx = signed'({{2{b1[4]}}, b3});
	assign sy = signed'({2'b00, b2});

	assign s_tready = !q_full;

	always_comb begin
		push_o.push        = s_tvalid && !q_full;
		push_o.entry.code  = {b0[7], b1[5], b0[6:0]};
		push_o.entry.color = b1[3:0];
		push_o.entry.flip  = flip_q;
		push_o.entry.pos_x = flip_q ? FLIP_ORIGIN - sx : sx;
		push_o.entry.pos_y = flip_q ? FLIP_ORIGIN - sy : sy;
		// height code 2 behaves as 3
		push_o.entry.top   = {b1[7], b1[7] | b1[6]};
	end

endmodule

`default_nettype wire

// File: hdl/sesd_queue.sv
// ----------------------------------------------------------------------------
// Sprite entry strip decoder - entry queue
// Small FIFO of decoded entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sprite_entry_strip_decoder_core_macros.svh"

module sesd_queue
	import sesd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push_i,
	output logic       full,
	output logic       head_valid,
	output entry_t     head,
	input  wire logic  pop
);

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_i.push) begin
			mem_q[wr_ptr_q] <= push_i.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_i.push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push_i.push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`SESD_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
	`SESD_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, count_q != '0, "pop from empty queue")
	`SESD_ASSERT_NOW(a_no_overflow, clk, arst_n, push_i.push, !full, "push into full queue")

endmodule

`default_nettype wire

// File: hdl/sesd_back.sv
// ----------------------------------------------------------------------------
// Sprite entry strip decoder - back end
// Walks strips of each entry from top index down and drives the output stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sprite_entry_strip_decoder_core_macros.svh"

module sesd_back
	import sesd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  head_valid,
	input  wire entry_t                head,
	output logic                       pop,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tlast
);

	logic              busy_q;
	entry_t            cur_q;
	logic [1:0]        idx_q;
	logic              m_tvalid_q, m_tlast_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	entry_t            src;
	logic [1:0]        src_idx;
	logic              src_valid, out_free, take;
	logic [9:0]        code_out;
	logic signed [9:0] step, y_out;

	assign src       = busy_q ? cur_q : head;
	assign src_idx   = busy_q ? idx_q : head.top;
	assign src_valid = busy_q || head_valid;
	assign out_free  = !m_tvalid_q || m_tready;
	assign take      = src_valid && out_free;
	assign pop       = take && !busy_q;

	assign code_out = {1'b0, src.code} + {8'b0, src_idx};
	assign step     = signed'({4'b0, src_idx, 4'b0});
	assign y_out    = src.flip ? src.pos_y - step : src.pos_y + step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q     <= (src_idx != 2'd0);
				idx_q      <= src_idx - 2'd1;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q     <= src;
			m_tlast_q <= (src_idx == 2'd0);
			m_tdata_q <= {5'b0, y_out, src.pos_x, src.flip, src.color, code_out};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`SESD_ASSERT_NOW(a_pop_idle, clk, arst_n, pop, !busy_q, "queue popped mid entry")
	`SESD_ASSERT_NEXT(a_last_flag, clk, arst_n, take && src_idx == 2'd0, m_tlast_q && !busy_q, "last strip not flagged")
	`SESD_ASSERT_NEXT(a_more_strips, clk, arst_n, take && src_idx != 2'd0, busy_q && !m_tlast_q, "strip walk ended early")

endmodule

`default_nettype wire

// File: hdl/sprite_entry_strip_decoder_core.sv
// ----------------------------------------------------------------------------
// Sprite entry strip decoder - top level
// Turns four-byte sprite attribute entries into 16-pixel strip draw items.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one attribute entry per item (bytes 0..3, byte 0 lowest).
//   m_* carries one strip draw item; tlast marks strip 0, the last of an entry.
//   cfg_wr_en/cfg_wr_data write the screen flip bit; write only when idle.
// Once an entry is taken, its first strip passes the queue register, then the output register.
// The back end emits 1 strip item per cycle while m_tready is high, into a
//   single output register; an entry gives 1, 2 or 4 strips, set by its
//   height code.
// A 2-entry queue sits between decode and the strip walker, so s_tready stays
//   high while the back end works on the previous entry, until the queue fills.
// Reset: queue empty, no output valid, screen flip cleared.
// Stall: with m_tready low the output item holds, the walker waits, and
//   s_tready drops once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_entry_strip_decoder_core
	import sesd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic                  cfg_wr_data,     // screen_flipped
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,         // attr_byte0..attr_byte3
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,         // tile_code, palette_color, tile_flip, pos_x, pos_y
	output logic                       m_tlast          // last_strip
);

	push_t  push;
	logic   q_full, head_valid, pop;
	entry_t head;

	sesd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.q_full      (q_full),
		.push_o      (push)
	);

	sesd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_i     (push),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	sesd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

// File: tb/sprite_entry_strip_decoder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite entry strip decoder - testbench
// Feeds attribute entries under both screen flip settings with random gaps on
// both stream sides; checks every strip item against a local decoder or table.
// ----------------------------------------------------------------------------

module sprite_entry_strip_decoder_core_tb;
	import sesd_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned PHASE_ITEMS = 70;

	typedef struct packed {
		logic [9:0]        code;
		logic [3:0]        color;
		logic              flip;
		logic signed [9:0] x;
		logic signed [9:0] y;
		logic              last;
	} strip_t;

	typedef struct packed {
		bit          flip;
		logic [31:0] ent;      // byte3, byte2, byte1, byte0
		bit          typed;    // exp holds the single strip of the entry
		strip_t      exp;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic                  cfg_wr_data = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	strip_t      strip_q[$];
	bit          screen_flip_model = 1'b0;
	bit          tx_busy = 1'b0;
	bit          rx_busy = 1'b0;
	int unsigned err_cnt = 0;
	int unsigned idle_cycles = 0;

	row_t dir_tab [14] = '{
		'{1'b0, 32'h0000_0000, 1'b1, '{10'd0,   4'd0,  1'b0, 10'sd0,    10'sd0,   1'b1}},
		'{1'b0, 32'hffff_3fff, 1'b1, '{10'd511, 4'd15, 1'b0, -10'sd1,   10'sd255, 1'b1}},
		'{1'b0, 32'h0000_1000, 1'b1, '{10'd0,   4'd0,  1'b0, -10'sd256, 10'sd0,   1'b1}},
		'{1'b0, 32'h8010_2080, 1'b1, '{10'd384, 4'd0,  1'b0, 10'sd128,  10'sd16,  1'b1}},
		'{1'b0, 32'h3344_4512, 1'b0, '0},
		'{1'b0, 32'h00f0_8a7f, 1'b0, '0},
		'{1'b0, 32'hff10_ffff, 1'b0, '0},
		'{1'b0, 32'h5aa5_d600, 1'b0, '0},
		'{1'b1, 32'h0000_0000, 1'b1, '{10'd0,   4'd0,  1'b1, 10'sd240,  10'sd240, 1'b1}},
		'{1'b1, 32'h0000_1000, 1'b1, '{10'd0,   4'd0,  1'b1, 10'sd496,  10'sd240, 1'b1}},
		'{1'b1, 32'hffff_0f7f, 1'b1, '{10'd127, 4'd15, 1'b1, -10'sd15,  -10'sd15, 1'b1}},
		'{1'b1, 32'h00ff_d080, 1'b0, '0},
		'{1'b1, 32'h7000_8b01, 1'b0, '0},
		'{1'b1, 32'h00ff_ffff, 1'b0, '0}
	};

	bit phase_flip [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

	sprite_entry_strip_decoder_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// strips of one entry, highest index first
	function automatic void predict_strips(input logic [31:0] ent);
		logic [7:0] b0, b1, b2, b3;
		logic [8:0] base;
		int sx, sy, dir, top;
		strip_t s;
		b0 = ent[7:0];
		b1 = ent[15:8];
		b2 = ent[23:16];
		b3 = ent[31:24];
		base = {b0[7], b1[5], b0[6:0]};
		sx = int'(b3) - (b1[4] ? 256 : 0);
		sy = int'(b2);
		dir = 1;
		if (screen_flip_model) begin
			sx = 240 - sx;
			sy = 240 - sy;
			dir = -1;
		end
		top = int'(b1[7:6]);
		if (top == 2)
			top = 3;
		for (int idx = top; idx >= 0; idx--) begin
			s.code  = 10'(base) + 10'(idx);
			s.color = b1[3:0];
			s.flip  = screen_flip_model;
			s.x     = 10'(sx);
			s.y     = 10'(sy + 16 * idx * dir);
			s.last  = (idx == 0);
			strip_q.push_back(s);
		end
	endfunction

	task automatic wait_drained();
		while (strip_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_flip(input bit f);
		wait_drained();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= f;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		screen_flip_model = f;
	endtask

	// valid stays high across back-to-back items
	task automatic send_entry(input logic [31:0] ent);
		int unsigned gap;
		gap = tx_busy ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ent;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	// sink
	initial begin
		int unsigned stall;
		strip_t got, want;
		@(posedge arst_n);
		forever begin
			stall = rx_busy ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			got.code  = m_tdata[9:0];
			got.color = m_tdata[13:10];
			got.flip  = m_tdata[14];
			got.x     = m_tdata[24:15];
			got.y     = m_tdata[34:25];
			got.last  = m_tlast;
			if (strip_q.size() == 0) begin
				$display("%0t: unexpected item, got code %0d x %0d y %0d", $time,
					got.code, got.x, got.y);
				err_cnt++;
			end else begin
				want = strip_q.pop_front();
				check_field("tile_code", int'(want.code), int'(got.code));
				check_field("palette_color", int'(want.color), int'(got.color));
				check_field("tile_flip", int'(want.flip), int'(got.flip));
				check_field("pos_x", int'(want.x), int'(got.x));
				check_field("pos_y", int'(want.y), int'(got.y));
				check_field("last_strip", int'(want.last), int'(got.last));
				check_field("tdata pad", 0, int'(m_tdata[OUT_DATA_W-1:35]));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("sprite_entry_strip_decoder_core_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] ent;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].flip != screen_flip_model) begin
				s_tvalid <= 1'b0;
				write_flip(dir_tab[i].flip);
			end
			send_entry(dir_tab[i].ent);
			if (dir_tab[i].typed)
				strip_q.push_back(dir_tab[i].exp);
			else
				predict_strips(dir_tab[i].ent);
		end
		s_tvalid <= 1'b0;

		foreach (phase_flip[p]) begin
			write_flip(phase_flip[p]);
			tx_busy = (p == 2);
			rx_busy = (p == 3 || p == 5);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				ent = $urandom;
				for (int b = 0; b < 4; b++) begin
					case ($urandom_range(0, 15))
						0: ent[8*b +: 8] = 8'h00;
						1: ent[8*b +: 8] = 8'hff;
						default: ;
					endcase
				end
				send_entry(ent);
				predict_strips(ent);
			end
			s_tvalid <= 1'b0;
		end
		tx_busy = 1'b0;
		rx_busy = 1'b0;

		wait_drained();
		repeat (24) @(posedge clk);
		if (err_cnt == 0)
			$display("sprite_entry_strip_decoder_core_tb: clean");
		else
			$display("sprite_entry_strip_decoder_core_tb: errors");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/sesd_pkg.sv
hdl/sesd_front.sv
hdl/sesd_queue.sv
hdl/sesd_back.sv
hdl/sprite_entry_strip_decoder_core.sv
tb/sprite_entry_strip_decoder_core_tb.sv
